// File: sv/brr_pkg.sv
// Shared types and constants for the bitmap range reduction block.
`default_nettype none

package brr_pkg;

  localparam int WORD_BITS   = 32;
  localparam int VECTOR_BITS = 65536;
  localparam int LANE_BITS   = 8;
  localparam int NUM_LANES   = WORD_BITS / LANE_BITS;

  localparam int POS_W      = 17;
  localparam int CNT_W      = 17;
  localparam int WNUM_W     = 11;
  localparam int OFF_W      = POS_W + 1;
  localparam int WORD_SHIFT = $clog2(WORD_BITS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int LANE_SEL_W = $clog2(LANE_BITS);
  localparam int LANE_IDX_W = $clog2(NUM_LANES);
  localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);
  localparam int WCNT_W     = $clog2(WORD_BITS + 1);
  localparam int CFG_IDX_W  = 1;

  localparam logic [POS_W-1:0] POS_MAX   = POS_W'(VECTOR_BITS);
  localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};
  localparam logic [POS_W-1:0] FROM_RST  = POS_W'(1);
  localparam logic [POS_W-1:0] TO_RST    = POS_W'(VECTOR_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_FROM = 1'b0,
    REG_RANGE_TO   = 1'b1
  } cfg_reg_t;

  // What one lane finds in its slice of the word.
  typedef struct packed {
    logic [LANE_CNT_W-1:0] cnt;
    logic                  any_set;
    logic                  any_clear;
    logic [BIT_IDX_W-1:0]  first_idx;
    logic [BIT_IDX_W-1:0]  last_idx;
  } lane_res_t;

  // Control for the word held between the lanes and the merge.
  typedef struct packed {
    logic              valid;
    logic              final_word;
    logic [WNUM_W-1:0] word_number;
  } stage_t;

  typedef struct packed {
    logic [CNT_W-1:0] set_count;
    logic             any_set;
    logic             all_set;
    logic             lowest_found;
    logic [POS_W-1:0] lowest_position;
    logic             highest_found;
    logic [POS_W-1:0] highest_position;
  } result_t;

endpackage

`default_nettype wire

// File: sv/brr_lane.sv
// One lane: masks, counts and priority-encodes one slice of a data word.
`default_nettype none

module brr_lane import brr_pkg::*; (
  input  logic [LANE_IDX_W-1:0]   lane_idx,
  input  logic [LANE_BITS-1:0]    slice,
  input  logic signed [OFF_W-1:0] lo_off,
  input  logic signed [OFF_W-1:0] hi_off,
  output lane_res_t               res
);

  logic [LANE_BITS-1:0]  in_rng;
  logic [LANE_BITS-1:0]  hit;
  logic [LANE_BITS-1:0]  miss;
  logic [LANE_SEL_W-1:0] first_sel;
  logic [LANE_SEL_W-1:0] last_sel;
  logic [LANE_CNT_W-1:0] cnt;

  // Bit k of the word lies in range when lo_off <= k < hi_off.
  always_comb begin
    logic signed [OFF_W-1:0] kk;
    for (int j = 0; j < LANE_BITS; j++) begin
      kk = signed'(OFF_W'({lane_idx, LANE_SEL_W'(j)}));
      in_rng[j] = (kk >= lo_off) && (kk < hi_off);
    end
  end

  assign hit  = slice & in_rng;
  assign miss = ~slice & in_rng;

  always_comb begin
    cnt       = '0;
    first_sel = '0;
    last_sel  = '0;
    for (int j = 0; j < LANE_BITS; j++) begin
      cnt = cnt + LANE_CNT_W'(hit[j]);
    end
    for (int j = LANE_BITS - 1; j >= 0; j--) begin
      if (hit[j]) first_sel = LANE_SEL_W'(j);
    end
    for (int j = 0; j < LANE_BITS; j++) begin
      if (hit[j]) last_sel = LANE_SEL_W'(j);
    end
  end

  assign res.cnt       = cnt;
  assign res.any_set   = |hit;
  assign res.any_clear = |miss;
  assign res.first_idx = {lane_idx, first_sel};
  assign res.last_idx  = {lane_idx, last_sel};

endmodule

`default_nettype wire

// File: sv/brr_merge.sv
// Merge stage: folds lane results into the running state and holds the result word.
`default_nettype none

module brr_merge import brr_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stage_t                      stage,
  input  lane_res_t [NUM_LANES-1:0]   lane_res,
  input  logic                        out_stall,
  output logic                        take,
  output logic                        out_valid,
  output result_t                     result
);

  logic [CNT_W-1:0] count_acc_r, count_acc_nxt;
  logic             any_acc_r, any_acc_nxt;
  logic             all_acc_r, all_acc_nxt;
  logic             low_seen_r, low_seen_nxt;
  logic [POS_W-1:0] low_pos_r, low_pos_nxt;
  logic             high_seen_r, high_seen_nxt;
  logic [POS_W-1:0] high_pos_r, high_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          result_r, result_nxt;

  logic [WCNT_W-1:0]    wcnt;
  logic                 wany;
  logic                 wclear;
  logic [BIT_IDX_W-1:0] wfirst;
  logic [BIT_IDX_W-1:0] wlast;
  logic [POS_W-1:0]     base;
  logic [POS_W-1:0]     wlow_pos;
  logic [POS_W-1:0]     whigh_pos;
  logic [POS_W:0]       cnt_sum;
  logic                 emit;

  // Take the held word unless it is final and the result slot is still full.
  assign take = stage.valid && (!stage.final_word || !out_valid_r || !out_stall);
  assign emit = take && stage.final_word;

  always_comb begin
    wcnt   = '0;
    wany   = 1'b0;
    wclear = 1'b0;
    wfirst = '0;
    wlast  = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      wcnt   = wcnt + WCNT_W'(lane_res[l].cnt);
      wany   = wany | lane_res[l].any_set;
      wclear = wclear | lane_res[l].any_clear;
    end
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      if (lane_res[l].any_set) wfirst = lane_res[l].first_idx;
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      if (lane_res[l].any_set) wlast = lane_res[l].last_idx;
    end
  end

  assign base      = POS_W'({stage.word_number, {WORD_SHIFT{1'b0}}});
  assign wlow_pos  = base + POS_W'(wfirst) + POS_W'(1);
  assign whigh_pos = base + POS_W'(wlast) + POS_W'(1);
  assign cnt_sum   = (POS_W + 1)'(count_acc_r) + (POS_W + 1)'(wcnt);

  always_comb begin
    count_acc_nxt = count_acc_r;
    any_acc_nxt   = any_acc_r;
    all_acc_nxt   = all_acc_r;
    low_seen_nxt  = low_seen_r;
    low_pos_nxt   = low_pos_r;
    high_seen_nxt = high_seen_r;
    high_pos_nxt  = high_pos_r;
    if (take) begin
      count_acc_nxt = cnt_sum[POS_W] ? CNT_SAT : cnt_sum[CNT_W-1:0];
      any_acc_nxt   = any_acc_r | wany;
      all_acc_nxt   = all_acc_r & ~wclear;
      if (wany && (!low_seen_r || wlow_pos < low_pos_r)) begin
        low_seen_nxt = 1'b1;
        low_pos_nxt  = wlow_pos;
      end
      if (wany && (!high_seen_r || whigh_pos > high_pos_r)) begin
        high_seen_nxt = 1'b1;
        high_pos_nxt  = whigh_pos;
      end
    end
  end

  always_comb begin
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      result_nxt.set_count        = count_acc_nxt;
      result_nxt.any_set          = any_acc_nxt;
      result_nxt.all_set          = all_acc_nxt;
      result_nxt.lowest_found     = low_seen_nxt;
      result_nxt.lowest_position  = low_pos_nxt;
      result_nxt.highest_found    = high_seen_nxt;
      result_nxt.highest_position = high_pos_nxt;
      out_valid_nxt               = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      count_acc_r <= '0;
      any_acc_r   <= 1'b0;
      all_acc_r   <= 1'b1;
      low_seen_r  <= 1'b0;
      low_pos_r   <= '0;
      high_seen_r <= 1'b0;
      high_pos_r  <= '0;
    end else begin
      count_acc_r <= count_acc_nxt;
      any_acc_r   <= any_acc_nxt;
      all_acc_r   <= all_acc_nxt;
      low_seen_r  <= low_seen_nxt;
      low_pos_r   <= low_pos_nxt;
      high_seen_r <= high_seen_nxt;
      high_pos_r  <= high_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

// File: sv/bitmap_range_reduction.sv
// Top level of the bitmap range reduction block.
//
// Usage: stream the words of a bit vector on the in_ channel, one word per
// accepted beat, with in_word_number giving the word's index and
// in_final_word marking the last word. Bit k of word n is position
// n*32 + k + 1. Only positions inside [range_from, range_to] are judged;
// range_from 0 acts as 1 and range_to is clipped to the vector size.
// On the final word one result word leaves on the out_ channel: set count
// (saturating), any/all flags, and the lowest and highest set positions.
// The running state clears right after that word is folded in.
// Configuration: write range_from (index 0) or range_to (index 1) through
// the cfg_ channel while no vector is in flight; cfg_ready is always high.
// Throughput: one word per cycle while in_stall is low, also across vector
// boundaries. The final word is held in the lanes' register first, and the
// merge loads the result register when it takes that word.
// Stalls: the result register holds while out_stall is high; the merge
// keeps taking non-final words, and in_stall rises only when a final word
// waits behind an undelivered result.
// Reset (rst_n low, synchronous) clears the running state, drops any held
// word and result, and restores range_from to 1 and range_to to 65536.
`default_nettype none

module bitmap_range_reduction import brr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_BITS-1:0] in_data_word,
  input  logic [WNUM_W-1:0]    in_word_number,
  input  logic                 in_final_word,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_W-1:0]     out_set_count,
  output logic                 out_any_set,
  output logic                 out_all_set,
  output logic                 out_lowest_found,
  output logic [POS_W-1:0]     out_lowest_position,
  output logic                 out_highest_found,
  output logic [POS_W-1:0]     out_highest_position,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_wdata
);

  logic [POS_W-1:0] range_from_r;
  logic [POS_W-1:0] range_to_r;
  logic [POS_W-1:0] lo_eff;
  logic [POS_W-1:0] hi_eff;
  logic [POS_W-1:0] in_base;

  logic signed [OFF_W-1:0] lo_off;
  logic signed [OFF_W-1:0] hi_off;

  lane_res_t [NUM_LANES-1:0] lane_res;
  lane_res_t [NUM_LANES-1:0] lane_res_r;
  stage_t                    stage_r, stage_nxt;
  logic                      take;
  logic                      in_accept;
  result_t                   result;

  // Register writes are always taken; index 0 writes range_from, index 1 range_to.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_from_r <= FROM_RST;
      range_to_r   <= TO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_FROM: range_from_r <= cfg_wdata;
        REG_RANGE_TO:   range_to_r   <= cfg_wdata;
      endcase
    end
  end

  // Clamp the range to the positions that exist.
  assign lo_eff = (range_from_r == '0) ? POS_W'(1) : range_from_r;
  assign hi_eff = (range_to_r > POS_MAX) ? POS_MAX : range_to_r;

  // Turn the range into bit offsets relative to this word: bit k is in range
  // when lo_off <= k < hi_off. An empty range yields no k at all.
  assign in_base = POS_W'({in_word_number, {WORD_SHIFT{1'b0}}});
  assign lo_off  = signed'({1'b0, lo_eff}) - OFF_W'(1) - signed'({1'b0, in_base});
  assign hi_off  = signed'({1'b0, hi_eff}) - signed'({1'b0, in_base});

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    brr_lane u_lane (
      .lane_idx (LANE_IDX_W'(l)),
      .slice    (in_data_word[l*LANE_BITS +: LANE_BITS]),
      .lo_off   (lo_off),
      .hi_off   (hi_off),
      .res      (lane_res[l])
    );
  end

  // Hold the word in the lane register while the merge cannot take it.
  assign in_stall  = stage_r.valid && !take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    stage_nxt       = stage_r;
    stage_nxt.valid = stage_r.valid && !take;
    if (in_accept) begin
      stage_nxt.valid       = 1'b1;
      stage_nxt.final_word  = in_final_word;
      stage_nxt.word_number = in_word_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.final_word  <= stage_nxt.final_word;
    stage_r.word_number <= stage_nxt.word_number;
    if (in_accept) begin
      lane_res_r <= lane_res;
    end
  end

  brr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage_r),
    .lane_res  (lane_res_r),
    .out_stall (out_stall),
    .take      (take),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_set_count        = result.set_count;
  assign out_any_set          = result.any_set;
  assign out_all_set          = result.all_set;
  assign out_lowest_found     = result.lowest_found;
  assign out_lowest_position  = result.lowest_position;
  assign out_highest_found    = result.highest_found;
  assign out_highest_position = result.highest_position;

endmodule

`default_nettype wire

// File: sv/brr_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module brr_checker import brr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CNT_W-1:0] out_set_count,
  input logic             out_any_set,
  input logic             out_lowest_found,
  input logic [POS_W-1:0] out_lowest_position,
  input logic             out_highest_found,
  input logic [POS_W-1:0] out_highest_position
);

  a_reset_drops_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word still valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_set_count)
      && $stable(out_lowest_position) && $stable(out_highest_position))
    else $error("stalled result word changed");

  a_found_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_any_set == out_lowest_found)
      && (out_lowest_found == out_highest_found))
    else $error("any/lowest/highest flags disagree");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_set |-> (out_set_count == '0)
      && (out_lowest_position == '0) && (out_highest_position == '0))
    else $error("no set bit but count or position nonzero");

  a_low_not_above_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lowest_found |-> (out_lowest_position <= out_highest_position)
      && (out_lowest_position != '0))
    else $error("lowest position above highest position");

endmodule

bind bitmap_range_reduction brr_checker u_brr_checker (.*);

`default_nettype wire
